### sv/flcu_pkg.sv
package flcu_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int VEC_FRAC_BITS = 14;

  // rotation CORDIC, Q30 internals, angles in 2^32 per turn
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'h028B0D43,  30'h0145D7E1,  30'h00A2F61E,  30'h00517C55,
    30'h0028BE53,  30'h00145F2F,  30'h000A2F98,  30'h000517CC,
    30'h00028BE6,  30'h000145F3,  30'h0000A2FA,  30'h0000517D,
    30'h000028BE,  30'h0000145F,  30'h00000A30,  30'h00000518,
    30'h0000028C,  30'h00000146,  30'h000000A3,  30'h00000051
  };

  // vector components clamp to +-1.0 and to the 16-bit range
  localparam int VEC_HI = (VEC_FRAC_BITS >= 15) ? 32767 : (1 << VEC_FRAC_BITS);
  localparam int VEC_LO = (VEC_FRAC_BITS >= 15) ? -32768 : -(1 << VEC_FRAC_BITS);

  localparam logic signed [31:0] POS_RESET_X = 32'sd327680;
  localparam logic signed [31:0] POS_RESET_Y = 32'sd1310720;
  localparam logic signed [31:0] POS_RESET_Z = 32'sd327680;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 2'd2;

  localparam logic [2:0] POS_X = 3'd0;
  localparam logic [2:0] POS_Y = 3'd1;
  localparam logic [2:0] POS_Z = 3'd2;

  localparam logic [2:0] DIR_FX = 3'd0;
  localparam logic [2:0] DIR_FY = 3'd1;
  localparam logic [2:0] DIR_FZ = 3'd2;
  localparam logic [2:0] DIR_LX = 3'd3;
  localparam logic [2:0] DIR_LZ = 3'd4;
  localparam logic [2:0] DIR_UX = 3'd5;
  localparam logic [2:0] DIR_UY = 3'd6;
  localparam logic [2:0] DIR_UZ = 3'd7;

  typedef enum logic [2:0] {
    CMD_STRAFE = 3'd0,
    CMD_FRONT  = 3'd1,
    CMD_YAW    = 3'd2,
    CMD_PITCH  = 3'd3,
    CMD_SET    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CORDIC,
    ST_ROUND,
    ST_DIRS,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    MS_CP_SY,
    MS_CP_CY,
    MS_FY_LZ,
    MS_FZ_LX,
    MS_FX_NLZ,
    MS_NFY_LX,
    MS_D_LX,
    MS_D_LZ,
    MS_D_FX,
    MS_D_FY,
    MS_D_FZ
  } mul_sel_e;

  typedef enum logic [1:0] {
    WR_ACC,
    WR_DIR,
    WR_DIR_SUM,
    WR_POS
  } wr_kind_e;

  typedef struct packed {
    mul_sel_e   sel;
    wr_kind_e   kind;
    logic [2:0] idx;
    logic       last;
  } uop_t;

  localparam int UOP_W = 4;
  localparam logic [UOP_W-1:0] UOP_RECOMPUTE = 4'd0;
  localparam logic [UOP_W-1:0] UOP_STRAFE    = 4'd6;
  localparam logic [UOP_W-1:0] UOP_FRONT     = 4'd8;

  typedef struct packed {
    logic              load;
    logic              set_pos;
    logic              turn_yaw;
    logic              turn_pitch;
    logic              cordic_init;
    logic              cordic_step;
    logic [STEP_W-1:0] step_idx;
    logic              sc_save;
    logic              dirs;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              wr_en;
    wr_kind_e          wr_kind;
    logic [2:0]        wr_idx;
    logic              pub;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] distance;
    logic signed [15:0] angle_delta;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] left_x;
    logic signed [15:0] left_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  // product / write micro-program: recompute, strafe, move front
  function automatic uop_t uop(input logic [UOP_W-1:0] i);
    uop_t u;
    unique case (i)
      4'd0:    u = '{MS_CP_SY,  WR_DIR,     DIR_FX, 1'b0};
      4'd1:    u = '{MS_CP_CY,  WR_DIR,     DIR_FZ, 1'b0};
      4'd2:    u = '{MS_FY_LZ,  WR_DIR,     DIR_UX, 1'b0};
      4'd3:    u = '{MS_FZ_LX,  WR_ACC,     DIR_UY, 1'b0};
      4'd4:    u = '{MS_FX_NLZ, WR_DIR_SUM, DIR_UY, 1'b0};
      4'd5:    u = '{MS_NFY_LX, WR_DIR,     DIR_UZ, 1'b1};
      4'd6:    u = '{MS_D_LX,   WR_POS,     POS_X,  1'b0};
      4'd7:    u = '{MS_D_LZ,   WR_POS,     POS_Z,  1'b1};
      4'd8:    u = '{MS_D_FX,   WR_POS,     POS_X,  1'b0};
      4'd9:    u = '{MS_D_FY,   WR_POS,     POS_Y,  1'b0};
      4'd10:   u = '{MS_D_FZ,   WR_POS,     POS_Z,  1'b1};
      default: u = '{MS_CP_SY,  WR_ACC,     POS_X,  1'b1};
    endcase
    return u;
  endfunction

  function automatic logic signed [15:0] clamp_vec(input logic signed [50:0] v);
    logic signed [15:0] r;
    if (v > 51'(VEC_HI)) begin
      r = 16'(VEC_HI);
    end else if (v < 51'(VEC_LO)) begin
      r = 16'(VEC_LO);
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < 51'(32'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/flcu_cordic.sv
module flcu_cordic #(
  parameter int ANGLE_BITS = flcu_pkg::ANGLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          init_i,
  input  logic                          step_i,
  input  logic [flcu_pkg::STEP_W-1:0]   step_idx_i,
  input  logic [ANGLE_BITS-1:0]         angle_i,
  output logic signed [15:0]            cos_o,
  output logic signed [15:0]            sin_o
);

  localparam int RSH = 30 - flcu_pkg::VEC_FRAC_BITS;
  localparam logic signed [34:0] RHALF = 35'sd1 <<< (RSH - 1);

  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic               flip_q;

  logic [31:0]        ang32;
  logic               fold;
  logic signed [32:0] z_init;
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  logic signed [33:0] xf, yf;
  logic signed [34:0] xr, yr;

  // quadrants 1 and 2 are rotated by a half turn and the result negated
  assign ang32  = 32'(angle_i) << (32 - ANGLE_BITS);
  assign fold   = ang32[31] ^ ang32[30];
  assign z_init = 33'(signed'({ang32[30], ang32[30:0]}));

  assign dx = y_q >>> step_idx_i;
  assign dy = x_q >>> step_idx_i;
  assign at = signed'({3'b000, flcu_pkg::ATAN_TURN[step_idx_i]});

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      x_q    <= flcu_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= fold;
    end else if (step_i) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign xr = (35'(xf) + RHALF) >>> RSH;
  assign yr = (35'(yf) + RHALF) >>> RSH;

  assign cos_o = flcu_pkg::clamp_vec(51'(xr));
  assign sin_o = flcu_pkg::clamp_vec(51'(yr));

endmodule

### sv/flcu_dp.sv
module flcu_dp #(
  parameter int ANGLE_BITS = flcu_pkg::ANGLE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  flcu_pkg::dp_cmd_t                cmd_i,
  input  flcu_pkg::in_item_t               in_item_i,
  input  logic                             cfg_we_i,
  input  logic [flcu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  output flcu_pkg::out_item_t              out_item_o
);

  localparam int EXT_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam logic signed [50:0] VHALF = 51'sd1 <<< (flcu_pkg::VEC_FRAC_BITS - 1);

  logic signed [31:0]   pos_q [3];
  logic signed [15:0]   dir_q [8];
  logic [ANGLE_BITS-1:0] yaw_q, pitch_q;
  logic signed [31:0]   dist_q;
  logic signed [15:0]   cp_q, sp_q, cy_q, sy_q;
  logic signed [48:0]   prod_q, acc_q;
  flcu_pkg::out_item_t  out_q;

  logic signed [EXT_W-1:0] dang_ext;
  logic [ANGLE_BITS-1:0]   dang;
  logic signed [15:0]      cp, sp, cy, sy;
  logic signed [31:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [48:0]      prod_d;
  logic signed [50:0]      sum, rnd, pos_sum;
  logic signed [31:0]      pos_sel;

  assign dang_ext = EXT_W'(in_item_i.angle_delta);
  assign dang     = dang_ext[ANGLE_BITS-1:0];

  flcu_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
    .clk_i      (clk_i),
    .init_i     (cmd_i.cordic_init),
    .step_i     (cmd_i.cordic_step),
    .step_idx_i (cmd_i.step_idx),
    .angle_i    (pitch_q),
    .cos_o      (cp),
    .sin_o      (sp)
  );

  flcu_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_yaw (
    .clk_i      (clk_i),
    .init_i     (cmd_i.cordic_init),
    .step_i     (cmd_i.cordic_step),
    .step_idx_i (cmd_i.step_idx),
    .angle_i    (yaw_q),
    .cos_o      (cy),
    .sin_o      (sy)
  );

  always_comb begin
    mul_a = dist_q;
    mul_b = 17'(dir_q[flcu_pkg::DIR_LX]);
    case (cmd_i.mul_sel)
      flcu_pkg::MS_CP_SY: begin
        mul_a = 32'(cp_q);
        mul_b = 17'(sy_q);
      end
      flcu_pkg::MS_CP_CY: begin
        mul_a = 32'(cp_q);
        mul_b = 17'(cy_q);
      end
      flcu_pkg::MS_FY_LZ: begin
        mul_a = 32'(dir_q[flcu_pkg::DIR_FY]);
        mul_b = 17'(dir_q[flcu_pkg::DIR_LZ]);
      end
      flcu_pkg::MS_FZ_LX: begin
        mul_a = 32'(dir_q[flcu_pkg::DIR_FZ]);
        mul_b = 17'(dir_q[flcu_pkg::DIR_LX]);
      end
      flcu_pkg::MS_FX_NLZ: begin
        mul_a = 32'(dir_q[flcu_pkg::DIR_FX]);
        mul_b = -17'(dir_q[flcu_pkg::DIR_LZ]);
      end
      flcu_pkg::MS_NFY_LX: begin
        mul_a = -32'(dir_q[flcu_pkg::DIR_FY]);
        mul_b = 17'(dir_q[flcu_pkg::DIR_LX]);
      end
      flcu_pkg::MS_D_LX: mul_b = 17'(dir_q[flcu_pkg::DIR_LX]);
      flcu_pkg::MS_D_LZ: mul_b = 17'(dir_q[flcu_pkg::DIR_LZ]);
      flcu_pkg::MS_D_FX: mul_b = 17'(dir_q[flcu_pkg::DIR_FX]);
      flcu_pkg::MS_D_FY: mul_b = 17'(dir_q[flcu_pkg::DIR_FY]);
      flcu_pkg::MS_D_FZ: mul_b = 17'(dir_q[flcu_pkg::DIR_FZ]);
      default: begin
        mul_a = dist_q;
        mul_b = 17'(dir_q[flcu_pkg::DIR_LX]);
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    case (cmd_i.wr_idx)
      flcu_pkg::POS_X: pos_sel = pos_q[0];
      flcu_pkg::POS_Y: pos_sel = pos_q[1];
      default:         pos_sel = pos_q[2];
    endcase
  end

  // round half up back to the vector fraction, then add to position if moving
  assign sum     = 51'(prod_q) +
                   ((cmd_i.wr_kind == flcu_pkg::WR_DIR_SUM) ? 51'(acc_q) : 51'sd0);
  assign rnd     = (sum + VHALF) >>> flcu_pkg::VEC_FRAC_BITS;
  assign pos_sum = 51'(pos_sel) + rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= flcu_pkg::POS_RESET_X;
      pos_q[1] <= flcu_pkg::POS_RESET_Y;
      pos_q[2] <= flcu_pkg::POS_RESET_Z;
      yaw_q    <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      pitch_q  <= '0;
      dir_q[flcu_pkg::DIR_FX] <= '0;
      dir_q[flcu_pkg::DIR_FY] <= '0;
      dir_q[flcu_pkg::DIR_FZ] <= 16'(flcu_pkg::VEC_LO);
      dir_q[flcu_pkg::DIR_LX] <= 16'(flcu_pkg::VEC_LO);
      dir_q[flcu_pkg::DIR_LZ] <= '0;
      dir_q[flcu_pkg::DIR_UX] <= '0;
      dir_q[flcu_pkg::DIR_UY] <= 16'(flcu_pkg::VEC_HI);
      dir_q[flcu_pkg::DIR_UZ] <= '0;
    end else begin
      if (cmd_i.turn_yaw) begin
        yaw_q <= yaw_q + dang;
      end
      if (cmd_i.turn_pitch) begin
        pitch_q <= pitch_q + dang;
      end
      if (cmd_i.set_pos) begin
        pos_q[0] <= in_item_i.new_x;
        pos_q[1] <= in_item_i.new_y;
        pos_q[2] <= in_item_i.new_z;
      end
      if (cmd_i.dirs) begin
        dir_q[flcu_pkg::DIR_FY] <= sp_q;
        dir_q[flcu_pkg::DIR_LX] <= cy_q;
        dir_q[flcu_pkg::DIR_LZ] <= flcu_pkg::clamp_vec(-51'(sy_q));
      end
      if (cmd_i.wr_en) begin
        if (cmd_i.wr_kind == flcu_pkg::WR_DIR || cmd_i.wr_kind == flcu_pkg::WR_DIR_SUM) begin
          dir_q[cmd_i.wr_idx] <= flcu_pkg::clamp_vec(rnd);
        end
        if (cmd_i.wr_kind == flcu_pkg::WR_POS) begin
          for (int k = 0; k < 3; k++) begin
            if (cmd_i.wr_idx == 3'(k)) begin
              pos_q[k] <= flcu_pkg::sat32(pos_sum);
            end
          end
        end
      end
      // start register writes land directly in the position
      if (cfg_we_i) begin
        if (cfg_idx_i == flcu_pkg::CFG_START_X) pos_q[0] <= cfg_data_i;
        if (cfg_idx_i == flcu_pkg::CFG_START_Y) pos_q[1] <= cfg_data_i;
        if (cfg_idx_i == flcu_pkg::CFG_START_Z) pos_q[2] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dist_q <= in_item_i.distance;
    end
    if (cmd_i.sc_save) begin
      cp_q <= cp;
      sp_q <= sp;
      cy_q <= cy;
      sy_q <= sy;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.wr_en && cmd_i.wr_kind == flcu_pkg::WR_ACC) begin
      acc_q <= prod_q;
    end
    if (cmd_i.pub) begin
      out_q.pos_x   <= pos_q[0];
      out_q.pos_y   <= pos_q[1];
      out_q.pos_z   <= pos_q[2];
      out_q.front_x <= dir_q[flcu_pkg::DIR_FX];
      out_q.front_y <= dir_q[flcu_pkg::DIR_FY];
      out_q.front_z <= dir_q[flcu_pkg::DIR_FZ];
      out_q.left_x  <= dir_q[flcu_pkg::DIR_LX];
      out_q.left_z  <= dir_q[flcu_pkg::DIR_LZ];
      out_q.up_x    <= dir_q[flcu_pkg::DIR_UX];
      out_q.up_y    <= dir_q[flcu_pkg::DIR_UY];
      out_q.up_z    <= dir_q[flcu_pkg::DIR_UZ];
    end
  end

  assign out_item_o = out_q;

endmodule

### sv/flcu_ctrl.sv
module flcu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output flcu_pkg::dp_cmd_t dp_cmd_o
);

  localparam logic [flcu_pkg::STEP_W-1:0] STEP_LAST =
    flcu_pkg::STEP_W'(flcu_pkg::CORDIC_STEPS - 1);

  flcu_pkg::state_e                state_q, state_d;
  logic [flcu_pkg::STEP_W-1:0]     step_q, step_d;
  logic [flcu_pkg::UOP_W-1:0]      uidx_q, uidx_d;
  logic                            out_valid_q, out_valid_d;
  flcu_pkg::uop_t                  u;
  flcu_pkg::dp_cmd_t               cmd;
  logic                            in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flcu_pkg::ST_IDLE;
      step_q      <= '0;
      uidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      uidx_q      <= uidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    uidx_d      = uidx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready    = 1'b0;
    u           = flcu_pkg::uop(uidx_q);
    cmd         = '0;
    cmd.step_idx = step_q;
    cmd.mul_sel  = u.sel;
    cmd.wr_kind  = u.kind;
    cmd.wr_idx   = u.idx;

    unique case (state_q)
      flcu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          unique case (in_cmd_i)
            flcu_pkg::CMD_STRAFE: begin
              uidx_d  = flcu_pkg::UOP_STRAFE;
              state_d = flcu_pkg::ST_MUL;
            end
            flcu_pkg::CMD_FRONT: begin
              uidx_d  = flcu_pkg::UOP_FRONT;
              state_d = flcu_pkg::ST_MUL;
            end
            flcu_pkg::CMD_YAW: begin
              cmd.turn_yaw = 1'b1;
              state_d      = flcu_pkg::ST_INIT;
            end
            flcu_pkg::CMD_PITCH: begin
              cmd.turn_pitch = 1'b1;
              state_d        = flcu_pkg::ST_INIT;
            end
            flcu_pkg::CMD_SET: begin
              cmd.set_pos = 1'b1;
              state_d     = flcu_pkg::ST_DONE;
            end
            default: state_d = flcu_pkg::ST_DONE;  // unused codes change nothing
          endcase
        end
      end
      flcu_pkg::ST_INIT: begin
        cmd.cordic_init = 1'b1;
        step_d          = '0;
        state_d         = flcu_pkg::ST_CORDIC;
      end
      flcu_pkg::ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = flcu_pkg::ST_ROUND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      flcu_pkg::ST_ROUND: begin
        cmd.sc_save = 1'b1;
        state_d     = flcu_pkg::ST_DIRS;
      end
      flcu_pkg::ST_DIRS: begin
        cmd.dirs = 1'b1;
        uidx_d   = flcu_pkg::UOP_RECOMPUTE;
        state_d  = flcu_pkg::ST_MUL;
      end
      flcu_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_d    = flcu_pkg::ST_WRITE;
      end
      flcu_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        if (u.last) begin
          state_d = flcu_pkg::ST_DONE;
        end else begin
          uidx_d  = uidx_q + 1'b1;
          state_d = flcu_pkg::ST_MUL;
        end
      end
      flcu_pkg::ST_DONE: begin
        // previous result must be gone before the output register reloads
        if (!out_valid_q || out_ready_i) begin
          cmd.pub     = 1'b1;
          out_valid_d = 1'b1;
          state_d     = flcu_pkg::ST_IDLE;
        end
      end
      default: state_d = flcu_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign dp_cmd_o    = cmd;

endmodule

### sv/free_look_camera_update.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o   in_item_i  (flcu_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_item_o (flcu_pkg::out_item_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item at a time. Set position and unused codes go straight to publish;
// strafe and move front run through the multiplier, and a turn runs 24 CORDIC
// iterations, both angles in parallel, then 6 products through one multiplier.
// in_ready_o is high only while idle; a held output only stalls the final publish.
// Reset: position from POS_RESET_X/Y/Z, yaw a half turn, pitch zero, default vectors.
module free_look_camera_update #(
  parameter int ANGLE_BITS = flcu_pkg::ANGLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  flcu_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output flcu_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [flcu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);

  flcu_pkg::dp_cmd_t dp_cmd;

  flcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_item_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  flcu_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

### sv/flcu_checker.sv
module flcu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input flcu_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input flcu_pkg::out_item_t out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transfer taken while busy");

  // set position result goes through the position and output registers when the output is free
  a_set_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.cmd == flcu_pkg::CMD_SET && !out_valid_o)
    |=> ##1 (out_valid_o && out_item_o.pos_x == $past(in_item_i.new_x, 2)
             && out_item_o.pos_y == $past(in_item_i.new_y, 2)
             && out_item_o.pos_z == $past(in_item_i.new_z, 2)))
    else $error("set position result wrong");

  // front y and left components never leave the unit range
  a_vec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.front_y <= 16'(flcu_pkg::VEC_HI) &&
       out_item_o.front_y >= 16'(flcu_pkg::VEC_LO) &&
       out_item_o.left_x  <= 16'(flcu_pkg::VEC_HI) &&
       out_item_o.left_x  >= 16'(flcu_pkg::VEC_LO) &&
       out_item_o.left_z  <= 16'(flcu_pkg::VEC_HI) &&
       out_item_o.left_z  >= 16'(flcu_pkg::VEC_LO)))
    else $error("vector component out of range");

endmodule

bind free_look_camera_update flcu_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### dv/camera_pose_checker.sv
module camera_pose_checker
  import flcu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VEC_ONE      = longint'(1) << VEC_FRAC_BITS;
  localparam longint POS_MAX      = 64'sd2147483647;
  localparam longint POS_MIN      = -64'sd2147483648;
  localparam longint CORDIC_K     = 64'sd652032874;
  localparam int     CORDIC_ITERS = 24;
  localparam int     PRINT_CAP    = 30;

  // atan(2^-i) in 2^32 units per turn
  localparam longint ARCTAN_STEP [CORDIC_ITERS] = '{
    'd536870912, 'd316933406, 'd167458907, 'd85004756,
    'h028B0D43,  'h0145D7E1,  'h00A2F61E,  'h00517C55,
    'h0028BE53,  'h00145F2F,  'h000A2F98,  'h000517CC,
    'h00028BE6,  'h000145F3,  'h0000A2FA,  'h0000517D,
    'h000028BE,  'h0000145F,  'h00000A30,  'h00000518,
    'h0000028C,  'h00000146,  'h000000A3,  'h00000051
  };

  // predicted camera state; the pose is also what every result reports
  out_item_t             pose;
  logic [ANGLE_BITS-1:0] yaw;
  logic [ANGLE_BITS-1:0] pitch;
  out_item_t             pose_q[$];
  out_item_t             want;

  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint unit_clamp(input longint v);
    if (v > VEC_ONE) return VEC_ONE;
    if (v < -VEC_ONE) return -VEC_ONE;
    return v;
  endfunction

  function automatic longint pos_sat(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void sin_cos_q14(input logic [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
    logic [31:0] a;
    longint      x, y, z, dx, dy;
    bit          flip;
    a = 32'(ang) << (32 - ANGLE_BITS);
    // second and third quadrant: rotate by a half turn, negate afterwards
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a - 32'h8000_0000;
    z = longint'($signed(a));
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_STEP[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = unit_clamp(rnd_shift(x, 30 - VEC_FRAC_BITS));
    s = unit_clamp(rnd_shift(y, 30 - VEC_FRAC_BITS));
  endfunction

  function automatic void refresh_axes();
    longint cp, sp, cy, sy, fx, fy, fz, lx, lz;
    sin_cos_q14(pitch, cp, sp);
    sin_cos_q14(yaw, cy, sy);
    fx = unit_clamp(rnd_shift(cp * sy, VEC_FRAC_BITS));
    fy = sp;
    fz = unit_clamp(rnd_shift(cp * cy, VEC_FRAC_BITS));
    lx = cy;
    lz = unit_clamp(-sy);
    pose.front_x = 16'(fx);
    pose.front_y = 16'(fy);
    pose.front_z = 16'(fz);
    pose.left_x  = 16'(lx);
    pose.left_z  = 16'(lz);
    // up = front x left, with left y = 0
    pose.up_x = 16'(unit_clamp(rnd_shift(fy * lz, VEC_FRAC_BITS)));
    pose.up_y = 16'(unit_clamp(rnd_shift(fz * lx - fx * lz, VEC_FRAC_BITS)));
    pose.up_z = 16'(unit_clamp(rnd_shift(-fy * lx, VEC_FRAC_BITS)));
  endfunction

  function automatic void advance(input longint t, input longint vx,
                                  input longint vy, input longint vz);
    pose.pos_x = 32'(pos_sat(longint'(pose.pos_x) + rnd_shift(t * vx, VEC_FRAC_BITS)));
    pose.pos_y = 32'(pos_sat(longint'(pose.pos_y) + rnd_shift(t * vy, VEC_FRAC_BITS)));
    pose.pos_z = 32'(pos_sat(longint'(pose.pos_z) + rnd_shift(t * vz, VEC_FRAC_BITS)));
  endfunction

  function automatic void apply_command(input in_item_t it);
    longint t;
    t = longint'($signed(it.distance));
    case (it.cmd)
      CMD_STRAFE: advance(t, longint'(pose.left_x), 0, longint'(pose.left_z));
      CMD_FRONT:  advance(t, longint'(pose.front_x), longint'(pose.front_y),
                          longint'(pose.front_z));
      CMD_YAW: begin
        yaw = yaw + ANGLE_BITS'(it.angle_delta);
        refresh_axes();
      end
      CMD_PITCH: begin
        pitch = pitch + ANGLE_BITS'(it.angle_delta);
        refresh_axes();
      end
      CMD_SET: begin
        pose.pos_x = it.new_x;
        pose.pos_y = it.new_y;
        pose.pos_z = it.new_z;
      end
      default: ;  // spare codes leave everything as it is
    endcase
  endfunction

  task automatic report(input string msg);
    fail_count_o++;
    if (fail_count_o <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("result %0d %s: got %0d, expected %0d",
                       checked_o, name, got, exp_val));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose         = '0;
      pose.pos_x   = POS_RESET_X;
      pose.pos_y   = POS_RESET_Y;
      pose.pos_z   = POS_RESET_Z;
      pose.front_z = 16'(-VEC_ONE);
      pose.left_x  = 16'(-VEC_ONE);
      pose.up_y    = 16'(VEC_ONE);
      yaw          = '0;
      yaw[ANGLE_BITS-1] = 1'b1;
      pitch        = '0;
      pose_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pose_q.size() == 0) begin
          report($sformatf("result %0d arrived with no command outstanding", checked_o));
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x",   out_item_i.pos_x,   want.pos_x);
          check_field("pos_y",   out_item_i.pos_y,   want.pos_y);
          check_field("pos_z",   out_item_i.pos_z,   want.pos_z);
          check_field("front_x", out_item_i.front_x, want.front_x);
          check_field("front_y", out_item_i.front_y, want.front_y);
          check_field("front_z", out_item_i.front_z, want.front_z);
          check_field("left_x",  out_item_i.left_x,  want.left_x);
          check_field("left_z",  out_item_i.left_z,  want.left_z);
          check_field("up_x",    out_item_i.up_x,    want.up_x);
          check_field("up_y",    out_item_i.up_y,    want.up_y);
          check_field("up_z",    out_item_i.up_z,    want.up_z);
        end
        checked_o++;
      end
      // a start write also moves the camera there at once
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_X: pose.pos_x = cfg_data_i;
          CFG_START_Y: pose.pos_y = cfg_data_i;
          CFG_START_Z: pose.pos_z = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(in_item_i);
        pose_q.push_back(pose);
      end
      pending_o = pose_q.size();
    end
  end

endmodule

### dv/free_look_camera_update_test.sv
module free_look_camera_update_test;
  timeunit 1ns;
  timeprecision 1ps;
  import flcu_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 3;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 185;
  localparam logic [2:0] CMD_NONE_LO = 3'(CMD_SET) + 3'd1;
  localparam logic [2:0] CMD_NONE_HI = 3'd7;
  localparam logic signed [31:0] D_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] D_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_UNIT = 32'sd65536;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int cfg_writes = 0;
  int by_cmd [8];
  bit hold_req = 1'b0;

  free_look_camera_update dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  camera_pose_checker pose_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // mostly modest values so the position does not pin at the rails
  function automatic logic signed [31:0] pick_word(input int span_bits);
    logic signed [31:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = $urandom_range(0, 1 << span_bits);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0:       v = D_MAX;
        1:       v = D_MIN;
        2:       v = '0;
        3:       v = 32'sd1;
        default: v = -32'sd1;
      endcase
    end
    return v;
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom);
    if (r < 90) return 16'($signed($urandom_range(0, 128)) - 64);
    case ($urandom_range(0, 4))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sd16384;
      3:       return -16'sd16384;
      default: return '0;
    endcase
  endfunction

  function automatic in_item_t cmd_item(input logic [2:0] c, input logic signed [31:0] d,
                                        input logic signed [15:0] a);
    in_item_t it;
    it.cmd         = c;
    it.distance    = d;
    it.angle_delta = a;
    it.new_x       = $urandom;
    it.new_y       = $urandom;
    it.new_z       = $urandom;
    return it;
  endfunction

  function automatic in_item_t set_item(input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
    in_item_t it;
    it       = cmd_item(CMD_SET, $urandom, 16'($urandom));
    it.new_x = x;
    it.new_y = y;
    it.new_z = z;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    if (r < 20)      c = CMD_STRAFE;
    else if (r < 45) c = CMD_FRONT;
    else if (r < 65) c = CMD_YAW;
    else if (r < 80) c = CMD_PITCH;
    else if (r < 92) c = CMD_SET;
    else             c = 3'($urandom_range(CMD_NONE_LO, CMD_NONE_HI));
    it       = cmd_item(c, pick_word(20), pick_angle());
    it.new_x = pick_word(24);
    it.new_y = pick_word(24);
    it.new_z = pick_word(24);
    return it;
  endfunction

  // valid stays up across back-to-back transfers; lowered only for a gap
  task automatic send(input in_item_t it, input int gap);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    by_cmd[it.cmd]++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START_X;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_START_Y;
    cfg_data_i <= y;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_START_Z;
    cfg_data_i <= z;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_writes += 3;
  endtask

  // output side: random ready, plus one long hold-off on request
  initial begin
    int r;
    int len;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready_i <= 1'b1;
          len = $urandom_range(1, 24);
        end else begin
          out_ready_i <= 1'b0;
          if (r < 92)      len = $urandom_range(1, 3);
          else if (r < 98) len = $urandom_range(4, 12);
          else             len = $urandom_range(25, 80);
        end
        repeat (len - 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    int burst_len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_START_X;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pose, then moves along the default axes
    send(cmd_item(CMD_NONE_LO, $urandom, 16'($urandom)), pick_gap());
    send(cmd_item(CMD_STRAFE, ONE_UNIT, 16'($urandom)), pick_gap());
    send(cmd_item(CMD_FRONT, -ONE_UNIT, 16'($urandom)), pick_gap());
    drain();
    write_start(D_MAX, D_MIN, '0);
    // position saturation both ways
    send(cmd_item(CMD_FRONT, D_MAX, 16'($urandom)), pick_gap());
    send(cmd_item(CMD_STRAFE, D_MIN, 16'($urandom)), pick_gap());
    send(cmd_item(CMD_STRAFE, D_MAX, 16'($urandom)), pick_gap());
    send(set_item(D_MAX, D_MIN, D_MAX), pick_gap());
    send(cmd_item(CMD_FRONT, D_MAX, 16'($urandom)), pick_gap());
    // turn extremes and wrap
    send(cmd_item(CMD_YAW, $urandom, 16'sh7fff), pick_gap());
    send(cmd_item(CMD_YAW, $urandom, 16'sh8000), pick_gap());
    send(cmd_item(CMD_YAW, $urandom, 16'sd1), pick_gap());
    send(cmd_item(CMD_YAW, $urandom, -16'sd1), pick_gap());
    send(cmd_item(CMD_YAW, $urandom, '0), pick_gap());
    // pitch straight up, then past a quarter turn (not limited)
    send(cmd_item(CMD_PITCH, $urandom, 16'sd16384), pick_gap());
    send(cmd_item(CMD_PITCH, $urandom, 16'sd16384), pick_gap());
    send(cmd_item(CMD_PITCH, $urandom, 16'sh8000), pick_gap());
    send(cmd_item(CMD_PITCH, $urandom, 16'sd8192), pick_gap());
    send(cmd_item(CMD_FRONT, D_MIN, 16'($urandom)), pick_gap());
    send(cmd_item(CMD_FRONT, D_MAX, 16'($urandom)), pick_gap());
    send(set_item(D_MIN, D_MIN, D_MIN), pick_gap());
    send(cmd_item(CMD_STRAFE, D_MIN, 16'($urandom)), pick_gap());
    send(cmd_item(3'($urandom_range(CMD_NONE_LO, CMD_NONE_HI)), $urandom, 16'($urandom)),
         pick_gap());
    send(cmd_item(CMD_NONE_HI, $urandom, 16'($urandom)), pick_gap());
    send(set_item('0, '0, '0), pick_gap());

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       write_start($urandom, $urandom, $urandom);
        1:       write_start(D_MAX, D_MAX, D_MAX);
        2:       write_start(D_MIN, D_MIN, D_MIN);
        3:       write_start('0, '0, '0);
        default: write_start(pick_word(24), pick_word(24), pick_word(24));
      endcase
      // long output hold while commands keep coming back to back
      if (p == 2) hold_req = 1'b1;
      burst_len = (p == 2) ? 40 : 25;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(random_command(), ((n % 80) < burst_len) ? 0 : pick_gap());
        if ((p == 1 && n == 60) || $urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d commands: %0d turns, %0d moves, %0d position loads, %0d spare",
             by_cmd.sum(), by_cmd[CMD_YAW] + by_cmd[CMD_PITCH],
             by_cmd[CMD_STRAFE] + by_cmd[CMD_FRONT], by_cmd[CMD_SET],
             by_cmd.sum() - by_cmd[CMD_YAW] - by_cmd[CMD_PITCH] - by_cmd[CMD_STRAFE]
             - by_cmd[CMD_FRONT] - by_cmd[CMD_SET]);
    $display("%0d results compared, %0d start writes, %0d cycles, %0d errors",
             checked, cfg_writes, cycles, fail_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/flcu_pkg.sv
sv/flcu_cordic.sv
sv/flcu_dp.sv
sv/flcu_ctrl.sv
sv/free_look_camera_update.sv
sv/flcu_checker.sv
dv/camera_pose_checker.sv
dv/free_look_camera_update_test.sv
